// ===== rtl/rast_pkg.sv =====
// Package for the range-AND segment tree: field widths, op codes,
// tree entry layout and default sizing. No dependencies.
`default_nettype none
package rast_pkg;
	localparam int DATA_W = 63;
	localparam int IDX_W = 11;
	localparam int OP_W = 2;
	localparam int LEAF_COUNT_DEF = 1024;
	localparam logic [DATA_W-1:0] ALL_ONES = {DATA_W{1'b1}};

	// operation codes; the spare code is ignored by the block
	localparam logic [OP_W-1:0] OP_APPLY  = 2'd0;
	localparam logic [OP_W-1:0] OP_ASSIGN = 2'd1;
	localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;
	localparam logic [OP_W-1:0] OP_SPARE  = 2'd3;

	// one tree node: lazy AND tag over the range, and AND of the range
	typedef struct packed {
		logic [DATA_W-1:0] tag;
		logic [DATA_W-1:0] val;
	} entry_t;
endpackage
`default_nettype wire

// ===== rtl/range_and_segment_tree.sv =====
// Range-AND lazy segment tree, one node RAM read per step of an item: point
// assign, range AND and query, with done raised in the last busy state of a
// query; one item at a time. Async reset then runs a clearing pass over all
// 2*N node entries (N rounded up to a power of two) with busy high.
// The result strobe lasts one cycle and cannot be stalled.
// Depends on rast_pkg and rast_ram.
`default_nettype none
module range_and_segment_tree
	import rast_pkg::*;
#(
	parameter int LEAF_COUNT = LEAF_COUNT_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	output logic                   done,
	input  wire logic [OP_W-1:0]   op,
	input  wire logic [IDX_W-1:0]  first_index,
	input  wire logic [IDX_W-1:0]  last_index,
	input  wire logic [DATA_W-1:0] operand_value,
	output logic      [DATA_W-1:0] and_result
);
	localparam int LOG = (LEAF_COUNT > 1) ? $clog2(LEAF_COUNT) : 1;
	localparam int NP = 1 << LOG;
	localparam int DEPTH = 2 * NP;
	localparam int AW = LOG + 1;
	localparam int IW = AW + 1;
	localparam int EW = ((AW > IDX_W) ? AW : IDX_W) + 1;
	localparam int LVW = $clog2(LOG + 1);

	typedef enum logic [16:0] {
		S_CLEAR    = 17'h00001,
		S_IDLE     = 17'h00002,
		S_PUSH_RD  = 17'h00004,
		S_PUSH_GET = 17'h00008,
		S_PUSH_WRC = 17'h00010,
		S_PUSH_WRP = 17'h00020,
		S_SET_LEAF = 17'h00040,
		S_COV      = 17'h00080,
		S_COV_DO   = 17'h00100,
		S_UP_RD0   = 17'h00200,
		S_UP_RD1   = 17'h00400,
		S_UP_RDP   = 17'h00800,
		S_UP_WR    = 17'h01000,
		S_TAG_RD   = 17'h02000,
		S_TAG_DO   = 17'h04000,
		S_DONE     = 17'h08000,
		S_FIN      = 17'h10000
	} state_t;

	state_t            state_q;
	logic [OP_W-1:0]   op_q;
	logic [AW-1:0]     leafa_q, leafb_q, node_q, clr_q;
	logic [IW-1:0]     l_q, r_q;
	logic [LVW-1:0]    lvl_q;
	logic              pass_q, sel_q;
	logic [DATA_W-1:0] val_q, acc_q, t_q, pv_q, v0_q;

	logic          we;
	logic [AW-1:0] waddr, raddr;
	entry_t        wdata, rdata;

	logic [EW-1:0] a_c, b_c, la_w, lb_w;
	logic          in_range, pt_ok;
	logic [AW-1:0] leaf_cur, path_p, child0, child1;

	rast_ram #(.WIDTH($bits(entry_t)), .DEPTH(DEPTH)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// clip the range to the array and map it to leaf node numbers
	always_comb begin
		a_c = (first_index == '0) ? EW'(1) : EW'(first_index);
		b_c = (EW'(last_index) > EW'(LEAF_COUNT)) ? EW'(LEAF_COUNT) : EW'(last_index);
		in_range = (a_c <= b_c);
		pt_ok = (first_index != '0) && (EW'(first_index) <= EW'(LEAF_COUNT));
		la_w = a_c - EW'(1) + EW'(NP);
		lb_w = b_c - EW'(1) + EW'(NP);
	end

	// ancestor of the current leaf at the current level, and its children
	assign leaf_cur = pass_q ? leafb_q : leafa_q;
	assign path_p = leaf_cur >> lvl_q;
	assign child0 = {path_p[AW-2:0], 1'b0};
	assign child1 = {path_p[AW-2:0], 1'b1};

	// memory port drive
	always_comb begin
		we = 1'b0;
		waddr = '0;
		wdata = '{tag: ALL_ONES, val: ALL_ONES};
		raddr = '0;
		case (state_q)
			S_CLEAR: begin
				we = 1'b1;
				waddr = clr_q;
			end
			S_PUSH_RD: raddr = path_p;
			S_PUSH_GET: raddr = child0;
			S_PUSH_WRC: begin
				we = 1'b1;
				waddr = sel_q ? child1 : child0;
				wdata = '{tag: rdata.tag & t_q, val: rdata.val & t_q};
				raddr = child1;
			end
			S_PUSH_WRP: begin
				we = 1'b1;
				waddr = path_p;
				wdata = '{tag: ALL_ONES, val: pv_q};
			end
			S_SET_LEAF: begin
				we = 1'b1;
				waddr = leafa_q;
				wdata = '{tag: ALL_ONES, val: val_q};
			end
			S_COV: raddr = (l_q[0] || r_q[0]) ? l_q[AW-1:0] : r_q[AW-1:0];
			S_COV_DO: begin
				we = (op_q == OP_APPLY);
				waddr = node_q;
				wdata = '{tag: rdata.tag & val_q, val: rdata.val & val_q};
			end
			S_UP_RD0: raddr = child0;
			S_UP_RD1: raddr = child1;
			S_UP_RDP: raddr = path_p;
			S_UP_WR: begin
				we = 1'b1;
				waddr = path_p;
				wdata = '{tag: rdata.tag, val: v0_q & rdata.tag};
			end
			S_TAG_RD: raddr = path_p;
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			op_q <= OP_APPLY;
			lvl_q <= '0;
			pass_q <= 1'b0;
			sel_q <= 1'b0;
			leafa_q <= '0;
			leafb_q <= '0;
			node_q <= '0;
			l_q <= '0;
			r_q <= '0;
			val_q <= '0;
			acc_q <= ALL_ONES;
			t_q <= ALL_ONES;
			pv_q <= ALL_ONES;
			v0_q <= ALL_ONES;
		end else begin
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(DEPTH - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (start) begin
						op_q <= op;
						val_q <= operand_value;
						acc_q <= ALL_ONES;
						pass_q <= 1'b0;
						leafa_q <= la_w[AW-1:0];
						leafb_q <= lb_w[AW-1:0];
						l_q <= IW'(la_w[AW-1:0]);
						r_q <= IW'(lb_w[AW-1:0]);
						case (op)
							// a valid position is never clipped, so leafa_q is its leaf
							OP_ASSIGN: begin
								lvl_q <= LVW'(LOG);
								state_q <= pt_ok ? S_PUSH_RD : S_FIN;
							end
							OP_APPLY: state_q <= in_range ? S_COV : S_FIN;
							OP_QUERY: state_q <= in_range ? S_COV : S_DONE;
							default: state_q <= S_FIN;
						endcase
					end
				end
				// push the ancestor tags one level toward the assigned leaf
				S_PUSH_RD: state_q <= S_PUSH_GET;
				S_PUSH_GET: begin
					t_q <= rdata.tag;
					pv_q <= rdata.val;
					sel_q <= 1'b0;
					state_q <= S_PUSH_WRC;
				end
				S_PUSH_WRC: begin
					sel_q <= 1'b1;
					if (sel_q) state_q <= S_PUSH_WRP;
				end
				S_PUSH_WRP: begin
					if (lvl_q == LVW'(1)) begin
						state_q <= S_SET_LEAF;
					end else begin
						lvl_q <= lvl_q - LVW'(1);
						state_q <= S_PUSH_RD;
					end
				end
				S_SET_LEAF: begin
					lvl_q <= LVW'(1);
					state_q <= S_UP_RD0;
				end
				// bottom-up walk over the covering nodes
				S_COV: begin
					if (l_q <= r_q) begin
						if (l_q[0]) begin
							node_q <= l_q[AW-1:0];
							l_q <= l_q + IW'(1);
							state_q <= S_COV_DO;
						end else if (!r_q[0]) begin
							node_q <= r_q[AW-1:0];
							r_q <= r_q - IW'(1);
							state_q <= S_COV_DO;
						end else begin
							l_q <= l_q >> 1;
							r_q <= r_q >> 1;
						end
					end else if (op_q == OP_APPLY) begin
						lvl_q <= LVW'(1);
						state_q <= S_UP_RD0;
					end else begin
						lvl_q <= '0;
						state_q <= S_TAG_RD;
					end
				end
				S_COV_DO: begin
					if (op_q == OP_QUERY) acc_q <= acc_q & rdata.val;
					state_q <= S_COV;
				end
				// recompute ancestors: node = left & right & own tag
				S_UP_RD0: state_q <= S_UP_RD1;
				S_UP_RD1: begin
					v0_q <= rdata.val;
					state_q <= S_UP_RDP;
				end
				S_UP_RDP: begin
					v0_q <= v0_q & rdata.val;
					state_q <= S_UP_WR;
				end
				S_UP_WR: begin
					if (lvl_q == LVW'(LOG)) begin
						if (op_q == OP_APPLY && !pass_q) begin
							pass_q <= 1'b1;
							lvl_q <= LVW'(1);
							state_q <= S_UP_RD0;
						end else begin
							state_q <= S_FIN;
						end
					end else begin
						lvl_q <= lvl_q + LVW'(1);
						state_q <= S_UP_RD0;
					end
				end
				// fold in the tags on both boundary paths
				S_TAG_RD: state_q <= S_TAG_DO;
				S_TAG_DO: begin
					acc_q <= acc_q & rdata.tag;
					if (lvl_q == LVW'(LOG)) begin
						if (!pass_q) begin
							pass_q <= 1'b1;
							lvl_q <= '0;
							state_q <= S_TAG_RD;
						end else begin
							state_q <= S_DONE;
						end
					end else begin
						lvl_q <= lvl_q + LVW'(1);
						state_q <= S_TAG_RD;
					end
				end
				S_DONE: state_q <= S_IDLE;
				S_FIN: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);
	assign and_result = acc_q;
endmodule
`default_nettype wire

// ===== rtl/rast_ram.sv =====
// Generic simple dual-port RAM, one write and one read port, registered read.
// No dependencies.
`default_nettype none
module rast_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ===== rtl/rast_check.sv =====
// Port-level checks for range_and_segment_tree, bound to the top level.
// Depends on rast_pkg.
`default_nettype none
module rast_check
	import rast_pkg::*;
(
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              start,
	input wire logic              busy,
	input wire logic              done,
	input wire logic [OP_W-1:0]   op,
	input wire logic [IDX_W-1:0]  first_index,
	input wire logic [IDX_W-1:0]  last_index,
	input wire logic [DATA_W-1:0] operand_value,
	input wire logic [DATA_W-1:0] and_result
);
	// a result only comes out of a transfer in progress
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("result strobe while idle");

	// an accepted transfer keeps the block busy in the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("accept not followed by busy");

	// accepted fields are known
	a_known_in: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> !$isunknown({op, first_index, last_index, operand_value}))
		else $error("unknown input fields at accept");

	// a delivered result is known
	a_known_out: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !$isunknown(and_result)) else $error("unknown result");

	// block is free right after delivering a result
	a_free: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy) else $error("busy after result");
endmodule

bind range_and_segment_tree rast_check u_rast_check (.*);
`default_nettype wire

// ===== tb/range_and_segment_tree_tb.sv =====
// Testbench for range_and_segment_tree: directed and random range-AND, point assign
// and query transfers, checked against a flat-array predictor of the element values.
// Depends on rast_pkg and the RTL of range_and_segment_tree.
`default_nettype none
module range_and_segment_tree_tb;
	import rast_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LEAVES = LEAF_COUNT_DEF;
	localparam int N_RANDOM = 1684;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [IDX_W-1:0]  first;
		logic [IDX_W-1:0]  last;
		logic [DATA_W-1:0] value;
	} cmd_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy, done;
	logic [OP_W-1:0] op = OP_APPLY;
	logic [IDX_W-1:0] first_index = '0;
	logic [IDX_W-1:0] last_index = '0;
	logic [DATA_W-1:0] operand_value = '0;
	logic [DATA_W-1:0] and_result;

	range_and_segment_tree dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
		.op(op), .first_index(first_index), .last_index(last_index),
		.operand_value(operand_value), .and_result(and_result)
	);

	cmd_t pending_cmds[$];
	logic [DATA_W-1:0] expected_ands[$];
	logic [DATA_W-1:0] elements[1:LEAVES];
	logic [DATA_W-1:0] exp_and;
	cmd_t cur_cmd;
	int errors = 0;
	int gap_left = 0;
	int n_issued = 0;
	int n_accepted = 0;
	int n_total = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	// Element-level predictor: the lazy tree is just an array of words
	function automatic void predict(cmd_t c);
		int lo, hi;
		logic [DATA_W-1:0] acc;
		lo = (c.first < 1) ? 1 : int'(c.first);
		hi = (c.last > LEAVES) ? LEAVES : int'(c.last);
		acc = ALL_ONES;
		case (c.op)
			OP_ASSIGN: begin
				if (c.first >= 1 && c.first <= LEAVES)
					elements[c.first] = c.value;
			end
			OP_APPLY: begin
				for (int i = lo; i <= hi; i++)
					elements[i] &= c.value;
			end
			OP_QUERY: begin
				for (int i = lo; i <= hi; i++)
					acc &= elements[i];
				expected_ands.push_back(acc);
			end
			default: ;
		endcase
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40) return 0;
		if (r < 90) return $urandom_range(1, 4);
		return $urandom_range(20, 150);
	endfunction

	function automatic logic [DATA_W-1:0] rand_word();
		logic [63:0] w;
		w = {$urandom(), $urandom()};
		return w[DATA_W-1:0];
	endfunction

	// mostly in range, some at the edges, some zero or past the array
	function automatic logic [IDX_W-1:0] rand_index();
		int r;
		r = $urandom_range(0, 99);
		if (r < 3) return '0;
		if (r < 6) return IDX_W'($urandom_range(LEAVES + 1, (1 << IDX_W) - 1));
		if (r < 15) return IDX_W'($urandom_range(1, 8));
		if (r < 24) return IDX_W'($urandom_range(LEAVES - 8, LEAVES));
		return IDX_W'($urandom_range(1, LEAVES));
	endfunction

	function automatic void push_cmd(logic [OP_W-1:0] o, int f, int l, logic [DATA_W-1:0] v);
		cmd_t c;
		c.op = o;
		c.first = IDX_W'(f);
		c.last = IDX_W'(l);
		c.value = v;
		pending_cmds.push_back(c);
	endfunction

	function automatic cmd_t rand_cmd();
		cmd_t c;
		int r;
		r = $urandom_range(0, 99);
		if (r < 30) c.op = OP_APPLY;
		else if (r < 62) c.op = OP_ASSIGN;
		else if (r < 95) c.op = OP_QUERY;
		else c.op = OP_SPARE;
		c.first = rand_index();
		if ($urandom_range(0, 1) == 1)
			c.last = IDX_W'(int'(c.first) + int'($urandom_range(0, 12)));
		else
			c.last = rand_index();
		// keep masks dense so queries still see ones
		if (c.op == OP_APPLY) begin
			if ($urandom_range(0, 99) < 70)
				c.value = ALL_ONES ^ (DATA_W'(1) << $urandom_range(0, DATA_W - 1));
			else
				c.value = rand_word() | rand_word() | rand_word();
		end else begin
			c.value = rand_word() | rand_word();
		end
		return c;
	endfunction

	// Stimulus, reset and end of run
	initial begin
		for (int i = 1; i <= LEAVES; i++)
			elements[i] = ALL_ONES;
		push_cmd(OP_QUERY, 1, LEAVES, '0);
		push_cmd(OP_QUERY, 0, 0, '0);
		push_cmd(OP_QUERY, 5, 3, '0);
		push_cmd(OP_ASSIGN, 0, 0, '0);
		push_cmd(OP_ASSIGN, LEAVES + 1, 0, '0);
		push_cmd(OP_QUERY, 1, LEAVES, '0);
		push_cmd(OP_ASSIGN, 1, 0, rand_word());
		push_cmd(OP_ASSIGN, LEAVES, 0, rand_word());
		push_cmd(OP_QUERY, 1, 1, '0);
		push_cmd(OP_QUERY, LEAVES, LEAVES, '0);
		push_cmd(OP_APPLY, 0, (1 << IDX_W) - 1, ALL_ONES ^ DATA_W'(5));
		push_cmd(OP_QUERY, 0, (1 << IDX_W) - 1, '0);
		push_cmd(OP_SPARE, 1, LEAVES, '0);
		push_cmd(OP_QUERY, (1 << IDX_W) - 1, (1 << IDX_W) - 1, '0);
		push_cmd(OP_APPLY, 9, 8, '0);
		push_cmd(OP_QUERY, 2, LEAVES - 1, '0);
		for (int k = 0; k < N_RANDOM; k++)
			pending_cmds.push_back(rand_cmd());
		n_total = pending_cmds.size();

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait (n_accepted == n_total);
		repeat (2) @(posedge clk);
		wait (!busy);
		repeat (2) @(posedge clk);
		if (expected_ands.size() != 0) begin
			$error("and_result: expected %0d more results, actual none", expected_ands.size());
			errors++;
		end
		if (errors == 0)
			$display("range_and_segment_tree: match");
		else
			$display("range_and_segment_tree: mismatch");
		$finish;
	end

	// Driver: one transfer per accepted start, random gaps between
	always @(negedge clk) begin
		if (arst_n) begin
			if (start && n_accepted == n_issued) begin
				start = 1'b0;
				gap_left = pick_gap();
			end
			if (!start) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_cmds.size() > 0) begin
					cur_cmd = pending_cmds.pop_front();
					op = cur_cmd.op;
					first_index = cur_cmd.first;
					last_index = cur_cmd.last;
					operand_value = cur_cmd.value;
					start = 1'b1;
					n_issued++;
				end
			end
		end
	end

	// Monitor: predict on each accepted transfer, check each result strobe
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				predict('{op: op, first: first_index, last: last_index,
					value: operand_value});
				n_accepted++;
			end
			if (done) begin
				if (expected_ands.size() == 0) begin
					$error("and_result: expected no result, actual %h", and_result);
					errors++;
				end else begin
					exp_and = expected_ands.pop_front();
					if (and_result !== exp_and) begin
						$error("and_result: expected %h, actual %h", exp_and, and_result);
						errors++;
					end
				end
			end
		end
	end

	// Run limit
	initial begin
		#20ms;
		$error("run did not finish in time");
		$display("range_and_segment_tree: mismatch");
		$finish;
	end
endmodule
`default_nettype wire

// ===== sim.f =====
rtl/rast_pkg.sv
rtl/rast_ram.sv
rtl/range_and_segment_tree.sv
rtl/rast_check.sv
tb/range_and_segment_tree_tb.sv
